// ===== src/rpc_pkg.sv =====
// Shared constants, widths, state and operation codes for the rolling
// Pearson correlation block. No dependencies.
`timescale 1ns / 1ps
package rpc_pkg;

    // Window and sample geometry
    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int N_W         = 7;
    localparam int SLOT_W      = $clog2(WINDOW_MAX);

    // Running sum widths
    localparam int SUM1_W = 31;
    localparam int SUM2_W = 54;

    // Datapath widths
    localparam int OPND_W   = 62;   // signed multiplier operand
    localparam int MAG_W    = 60;   // operand magnitude
    localparam int PROD_W   = 120;  // serial product / root operand
    localparam int DIV_W    = 96;   // divider remainder and shifted divisor
    localparam int FRAC_OUT = 30;
    localparam int Q_W      = 33;
    localparam int DIV_STEPS = 33;
    localparam int CNT_W    = 6;

    localparam logic [N_W-1:0] WIN_RESET = 7'd30;
    localparam logic [N_W-1:0] WIN_MIN   = 7'd2;
    localparam logic [Q_W-1:0] ONE_Q     = 33'h040000000;

    // Register index
    localparam logic CFG_WINDOW_LEN = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_OLD,
        S_LOAD,
        S_MUL,
        S_FIX,
        S_APPLY,
        S_SQRT,
        S_DIVP,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_XY,
        OP_XX,
        OP_YY,
        OP_OXY,
        OP_OXX,
        OP_OYY,
        OP_NXY,
        OP_SXY,
        OP_NXX,
        OP_SXX,
        OP_NYY,
        OP_SYY,
        OP_VV
    } t_op;

endpackage

// ===== src/rolling_pearson_correlation_top.sv =====
// Rolling Pearson correlation: sample window memory, running sums and a
// shared bit-serial multiplier, square root and divider. Uses rpc_pkg.
//
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_x_sample, i_y_sample, i_restart
// result    out        o_valid / i_ready  o_correlation, o_degenerate
// config    in         APB (pready = 1)   window_len at byte address 0
//
// One item at a time. Each product is formed bit-serially, one step per bit of its
// second operand up to its highest set bit. While the window fills an item ends
// after its own three products and gives no result; once it is full the 60-step
// root and the 33-step divider follow the products.
// Reset needs no clearing pass. The result register holds a finished item, so a
// stalled output delays only the item after that.
`timescale 1ns / 1ps
module rolling_pearson_correlation_top
    import rpc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_x_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_y_sample,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_correlation,
    output logic                          o_degenerate
);

    t_state r_state, n_state;
    t_op    r_op, w_op_next;

    logic [N_W-1:0]    r_window_len;
    logic [SLOT_W-1:0] r_slot;
    logic [N_W-1:0]    r_fill;
    logic              r_old;
    logic              r_rst;

    logic signed [SAMPLE_BITS-1:0] r_x, r_y, r_rd_x, r_rd_y;
    logic signed [SUM1_W-1:0] r_sx, r_sy;
    logic signed [SUM2_W-1:0] r_sxy, r_sxx, r_syy;

    logic signed [SAMPLE_BITS-1:0] r_xmem [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] r_ymem [WINDOW_MAX];

    logic [PROD_W-1:0] r_ma, r_acc;
    logic [MAG_W-1:0]  r_mb;
    logic              r_neg;

    logic signed [OPND_W-1:0] r_num, r_vx, r_vy;

    logic [PROD_W-1:0] r_sop, r_res, r_one;

    logic [DIV_W-1:0] r_rem, r_d;
    logic [Q_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_dneg, r_zero;

    logic              r_ovalid, r_deg;
    logic signed [31:0] r_corr;

    // Effective window length and configuration write
    logic [N_W-1:0] w_n;
    logic           w_cfg_wr;
    assign w_n = (r_window_len < WIN_MIN) ? WIN_MIN :
                 (r_window_len > N_W'(WINDOW_MAX)) ? N_W'(WINDOW_MAX) : r_window_len;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_WINDOW_LEN);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == CFG_WINDOW_LEN) ? {25'd0, r_window_len} : 32'd0;

    // Slot and fill bookkeeping for the item being taken
    logic [SLOT_W-1:0] w_slot0;
    logic [N_W-1:0]    w_fill0, w_slot_inc;
    logic              w_old;
    assign w_slot0    = (r_rst || ({1'b0, r_slot} >= w_n)) ? '0 : r_slot;
    assign w_fill0    = r_rst ? '0 : r_fill;
    assign w_old      = (w_fill0 >= w_n);
    assign w_slot_inc = {1'b0, w_slot0} + N_W'(1);

    // Sign-extended operand sources
    logic signed [OPND_W-1:0] w_x, w_y, w_ox, w_oy, w_sx, w_sy, w_sxy, w_sxx, w_syy, w_nn;
    assign w_x   = OPND_W'(r_x);
    assign w_y   = OPND_W'(r_y);
    assign w_ox  = OPND_W'(r_rd_x);
    assign w_oy  = OPND_W'(r_rd_y);
    assign w_sx  = OPND_W'(r_sx);
    assign w_sy  = OPND_W'(r_sy);
    assign w_sxy = OPND_W'(r_sxy);
    assign w_sxx = OPND_W'(r_sxx);
    assign w_syy = OPND_W'(r_syy);
    assign w_nn  = OPND_W'($signed({1'b0, w_n}));

    // Operand select per operation
    logic signed [OPND_W-1:0] w_a, w_b;
    logic [OPND_W-1:0]        w_aabs, w_babs;
    always_comb begin
        case (r_op)
            OP_XY:   begin w_a = w_x;   w_b = w_y;  end
            OP_XX:   begin w_a = w_x;   w_b = w_x;  end
            OP_YY:   begin w_a = w_y;   w_b = w_y;  end
            OP_OXY:  begin w_a = w_ox;  w_b = w_oy; end
            OP_OXX:  begin w_a = w_ox;  w_b = w_ox; end
            OP_OYY:  begin w_a = w_oy;  w_b = w_oy; end
            OP_NXY:  begin w_a = w_sxy; w_b = w_nn; end
            OP_SXY:  begin w_a = w_sx;  w_b = w_sy; end
            OP_NXX:  begin w_a = w_sxx; w_b = w_nn; end
            OP_SXX:  begin w_a = w_sx;  w_b = w_sx; end
            OP_NYY:  begin w_a = w_syy; w_b = w_nn; end
            OP_SYY:  begin w_a = w_sy;  w_b = w_sy; end
            OP_VV:   begin w_a = r_vx;  w_b = r_vy; end
            default: begin w_a = '0;    w_b = '0;   end
        endcase
    end
    assign w_aabs = w_a[OPND_W-1] ? (~w_a + OPND_W'(1)) : w_a;
    assign w_babs = w_b[OPND_W-1] ? (~w_b + OPND_W'(1)) : w_b;

    // Operation sequence
    always_comb begin
        case (r_op)
            OP_XY:   w_op_next = OP_XX;
            OP_XX:   w_op_next = OP_YY;
            OP_YY:   w_op_next = r_old ? OP_OXY : OP_NXY;
            OP_OXY:  w_op_next = OP_OXX;
            OP_OXX:  w_op_next = OP_OYY;
            OP_OYY:  w_op_next = OP_NXY;
            OP_NXY:  w_op_next = OP_SXY;
            OP_SXY:  w_op_next = OP_NXX;
            OP_NXX:  w_op_next = OP_SXX;
            OP_SXX:  w_op_next = OP_NYY;
            OP_NYY:  w_op_next = OP_SYY;
            OP_SYY:  w_op_next = OP_VV;
            default: w_op_next = OP_XY;
        endcase
    end

    // Root and divider steps
    logic [PROD_W-1:0] w_rt;
    logic [PROD_W:0]   w_rdiff;
    logic [DIV_W:0]    w_ddiff;
    logic [OPND_W-1:0] w_nmag;
    logic [Q_W-1:0]    w_qc;
    logic              w_out_free;
    assign w_rt       = r_res + r_one;
    assign w_rdiff    = {1'b0, r_sop} - {1'b0, w_rt};
    assign w_ddiff    = {1'b0, r_rem} - {1'b0, r_d};
    assign w_nmag     = r_num[OPND_W-1] ? (~r_num + OPND_W'(1)) : r_num;
    assign w_qc       = (r_q > ONE_Q) ? ONE_Q : r_q;
    assign w_out_free = !r_ovalid || i_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_PREP;
            S_PREP:  n_state = S_OLD;
            S_OLD:   n_state = S_LOAD;
            S_LOAD:  n_state = S_MUL;
            S_MUL:   if (r_mb == '0) n_state = S_FIX;
            S_FIX:   n_state = S_APPLY;
            S_APPLY: begin
                if (r_op == OP_VV) begin
                    n_state = S_SQRT;
                end else if ((w_op_next == OP_NXY) && (r_op != OP_SXY) &&
                             (r_fill < w_n)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_SQRT:  if (r_one == '0) n_state = S_DIVP;
            S_DIVP:  n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    // Window memory: old entry read before the new one lands
    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_rd_x <= r_xmem[w_slot0];
            r_rd_y <= r_ymem[w_slot0];
            r_xmem[w_slot0] <= r_x;
            r_ymem[w_slot0] <= r_y;
        end
    end

    // Control registers: window length, slot, fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WIN_RESET;
            r_slot       <= '0;
            r_fill       <= '0;
        end else if (w_cfg_wr) begin
            r_window_len <= pwdata[N_W-1:0];
            r_slot       <= '0;
            r_fill       <= '0;
        end else if (r_state == S_PREP) begin
            r_fill <= w_old ? w_fill0 : w_fill0 + N_W'(1);
            r_slot <= (w_slot_inc >= w_n) ? '0 : w_slot_inc[SLOT_W-1:0];
        end
    end

    // Running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_wr) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
            r_syy <= '0;
        end else begin
            case (r_state)
                S_PREP: begin
                    r_sx <= (r_rst ? '0 : r_sx) + SUM1_W'(r_x);
                    r_sy <= (r_rst ? '0 : r_sy) + SUM1_W'(r_y);
                    if (r_rst) begin
                        r_sxy <= '0;
                        r_sxx <= '0;
                        r_syy <= '0;
                    end
                end
                S_OLD: begin
                    if (r_old) begin
                        r_sx <= r_sx - SUM1_W'(r_rd_x);
                        r_sy <= r_sy - SUM1_W'(r_rd_y);
                    end
                end
                S_APPLY: begin
                    case (r_op)
                        OP_XY:   r_sxy <= r_sxy + $signed(r_acc[SUM2_W-1:0]);
                        OP_XX:   r_sxx <= r_sxx + $signed(r_acc[SUM2_W-1:0]);
                        OP_YY:   r_syy <= r_syy + $signed(r_acc[SUM2_W-1:0]);
                        OP_OXY:  r_sxy <= r_sxy - $signed(r_acc[SUM2_W-1:0]);
                        OP_OXX:  r_sxx <= r_sxx - $signed(r_acc[SUM2_W-1:0]);
                        OP_OYY:  r_syy <= r_syy - $signed(r_acc[SUM2_W-1:0]);
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Item latch, serial multiplier, root and divider datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x   <= i_x_sample;
                r_y   <= i_y_sample;
                r_rst <= i_restart;
            end
            S_PREP: r_old <= w_old;
            S_OLD:  r_op  <= OP_XY;
            S_LOAD: begin
                r_ma  <= PROD_W'(w_aabs[MAG_W-1:0]);
                r_mb  <= w_babs[MAG_W-1:0];
                r_neg <= w_a[OPND_W-1] ^ w_b[OPND_W-1];
                r_acc <= '0;
            end
            // One multiplier bit a cycle, stops when the rest is zero
            S_MUL: begin
                if (r_mb != '0) begin
                    if (r_mb[0]) r_acc <= r_acc + r_ma;
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
            end
            S_FIX: if (r_neg) r_acc <= ~r_acc + PROD_W'(1);
            S_APPLY: begin
                r_op <= w_op_next;
                case (r_op)
                    OP_NXY:  r_num <= $signed(r_acc[OPND_W-1:0]);
                    OP_SXY:  r_num <= r_num - $signed(r_acc[OPND_W-1:0]);
                    OP_NXX:  r_vx  <= $signed(r_acc[OPND_W-1:0]);
                    OP_SXX:  r_vx  <= r_vx - $signed(r_acc[OPND_W-1:0]);
                    OP_NYY:  r_vy  <= $signed(r_acc[OPND_W-1:0]);
                    OP_SYY:  r_vy  <= r_vy - $signed(r_acc[OPND_W-1:0]);
                    OP_VV: begin
                        r_sop <= r_acc;
                        r_res <= '0;
                        r_one <= PROD_W'(1) << (PROD_W - 2);
                    end
                    default: ;
                endcase
            end
            // Floored root, two operand bits a step
            S_SQRT: begin
                if (r_one != '0) begin
                    if (!w_rdiff[PROD_W]) begin
                        r_sop <= w_rdiff[PROD_W-1:0];
                        r_res <= (r_res >> 1) + r_one;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_one <= r_one >> 2;
                end
            end
            S_DIVP: begin
                r_zero <= (r_res == '0);
                r_dneg <= r_num[OPND_W-1];
                r_rem  <= DIV_W'(w_nmag) << FRAC_OUT;
                r_d    <= DIV_W'(r_res[MAG_W-1:0]) << (Q_W - 1);
                r_q    <= '0;
                r_cnt  <= '0;
            end
            // Restoring division, one quotient bit a step
            S_DIV: begin
                if (!w_ddiff[DIV_W]) begin
                    r_rem <= w_ddiff[DIV_W-1:0];
                    r_q   <= {r_q[Q_W-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[Q_W-2:0], 1'b0};
                end
                r_d   <= r_d >> 1;
                r_cnt <= r_cnt + CNT_W'(1);
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_deg  <= r_zero;
            if (r_zero) begin
                r_corr <= '0;
            end else if (r_dneg) begin
                r_corr <= $signed(32'd0 - w_qc[31:0]);
            end else begin
                r_corr <= $signed(w_qc[31:0]);
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_correlation = r_corr;
    assign o_degenerate  = r_deg;

endmodule

// ===== tb/rolling_pearson_correlation_top_tb.sv =====
// Testbench for rolling_pearson_correlation_top: drives sample pairs and APB
// window writes, predicts every correlation result in a scoreboard class.
// Depends on rpc_pkg and the rolling_pearson_correlation_top RTL.
`timescale 1ns / 1ps

// Expected correlation and degenerate flag for one windowed pair
typedef struct {
    logic signed [31:0] corr;
    logic               degen;
} t_corr_result;

// Scoreboard: keeps its own copy of the window and running sums
class t_corr_scoreboard;
    logic [rpc_pkg::N_W-1:0] win_reg;
    int                      x_hist[rpc_pkg::WINDOW_MAX];
    int                      y_hist[rpc_pkg::WINDOW_MAX];
    int unsigned             slot;
    int unsigned             filled;
    longint                  sum_x, sum_y, sum_xy, sum_xx, sum_yy;
    t_corr_result            pending[$];
    int                      mismatches;
    int                      checked;
    int                      degen_seen;

    function new();
        win_reg    = rpc_pkg::WIN_RESET;
        mismatches = 0;
        checked    = 0;
        degen_seen = 0;
        clear_sums();
    endfunction

    function void clear_sums();
        slot   = 0;
        filled = 0;
        sum_x  = 0;
        sum_y  = 0;
        sum_xy = 0;
        sum_xx = 0;
        sum_yy = 0;
    endfunction

    // Register write; index 0 is the only register, others are ignored
    function void write_reg(int unsigned index, logic [31:0] value);
        if (index == rpc_pkg::CFG_WINDOW_LEN) begin
            win_reg = value[rpc_pkg::N_W-1:0];
            clear_sums();
        end
    endfunction

    function int unsigned active_len();
        if (win_reg < rpc_pkg::WIN_MIN) return rpc_pkg::WIN_MIN;
        if (win_reg > rpc_pkg::WINDOW_MAX) return rpc_pkg::WINDOW_MAX;
        return win_reg;
    endfunction

    // Accepted input pair: update window, queue the coefficient if full
    function void note_pair(logic signed [23:0] xs, logic signed [23:0] ys, logic rst);
        int unsigned        n;
        longint             xv, yv, ox, oy;
        logic signed [191:0] wn, num, vx, vy;
        logic [191:0]       prod, root, trial, mag, quo;
        t_corr_result       res;
        n  = active_len();
        xv = xs;
        yv = ys;
        if (rst) clear_sums();
        if (slot >= n) slot = 0;
        if (filled >= n) begin
            ox = x_hist[slot];
            oy = y_hist[slot];
            sum_x  -= ox;
            sum_y  -= oy;
            sum_xy -= ox * oy;
            sum_xx -= ox * ox;
            sum_yy -= oy * oy;
        end else begin
            filled++;
        end
        x_hist[slot] = int'(xv);
        y_hist[slot] = int'(yv);
        sum_x  += xv;
        sum_y  += yv;
        sum_xy += xv * yv;
        sum_xx += xv * xv;
        sum_yy += yv * yv;
        slot = (slot + 1 >= n) ? 0 : slot + 1;
        if (filled < n) return;

        wn  = n;
        num = wn * 192'(sum_xy) - 192'(sum_x) * 192'(sum_y);
        vx  = wn * 192'(sum_xx) - 192'(sum_x) * 192'(sum_x);
        vy  = wn * 192'(sum_yy) - 192'(sum_y) * 192'(sum_y);
        prod = vx * vy;
        // floored square root, bit by bit
        root = '0;
        for (int k = 94; k >= 0; k--) begin
            trial = root | (192'(1) << k);
            if (trial * trial <= prod) root = trial;
        end
        if (root == 0) begin
            res.corr  = '0;
            res.degen = 1'b1;
        end else begin
            mag = num[191] ? -num : num;
            quo = (mag << rpc_pkg::FRAC_OUT) / root;
            if (quo > (192'(1) << rpc_pkg::FRAC_OUT)) quo = 192'(1) << rpc_pkg::FRAC_OUT;
            res.corr  = num[191] ? -quo[31:0] : quo[31:0];
            res.degen = 1'b0;
        end
        pending.insert(pending.size(), res);
    endfunction

    // Compare one output item with the oldest expectation
    function void check_result(logic signed [31:0] corr, logic degen);
        t_corr_result want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result corr=%0d degen=%0b", $realtime, corr, degen);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (degen) degen_seen++;
        if (corr !== want.corr || degen !== want.degen) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: corr exp %0d got %0d, degen exp %0b got %0b",
                         $realtime, want.corr, corr, want.degen, degen);
        end
    endfunction
endclass

module rolling_pearson_correlation_top_tb;
    import rpc_pkg::*;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [2:0]                    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_x_sample = '0;
    logic signed [SAMPLE_BITS-1:0] i_y_sample = '0;
    logic                          i_restart = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic signed [31:0]            o_correlation;
    logic                          o_degenerate;

    t_corr_scoreboard sb = new();
    int               pairs_sent = 0;
    bit               stall_on = 1'b0;

    rolling_pearson_correlation_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Short gaps mostly, a long one now and then
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return 0;
        if (pick < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure
    always @(negedge i_clk) begin
        if (!stall_on) i_ready <= 1'b1;
        else i_ready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_correlation, o_degenerate);
    end

    // APB register write: setup then access phase
    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(addr >> 2, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // One input item through the valid/ready handshake
    task automatic send_pair(logic signed [23:0] xs, logic signed [23:0] ys, logic rst);
        repeat (gap_len()) @(negedge i_clk);
        i_valid    = 1'b1;
        i_x_sample = xs;
        i_y_sample = ys;
        i_restart  = rst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_pair(xs, ys, rst);
        pairs_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Drain expectations, then let a result-free item finish before a write
    task automatic wait_idle();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    // Random pair; style picks full range, tracking, constant, extreme or anti-correlated data
    task automatic random_pair(int style);
        logic signed [23:0] xs, ys;
        xs = 24'($urandom);
        ys = 24'($urandom);
        case (style)
            0: ;
            1: ys = xs + 24'($signed($urandom_range(0, 2000)) - 1000);
            2: xs = 24'h123456;
            3: begin
                xs = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
                ys = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
            end
            default: ys = -xs;
        endcase
        send_pair(xs, ys, $urandom_range(0, 99) < 4);
    endtask

    initial begin
        int          lens[$];
        int unsigned wl;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset window (30) with extremes and perfect correlation
        for (int i = 0; i < 30; i++) send_pair(i[0] ? 24'h7FFFFF : 24'h800000,
                                               i[0] ? 24'h7FFFFF : 24'h800000, 1'b0);
        wait_idle();
        // Shortest window: degenerate, anti-correlated, restart mid-window
        apb_write(3'd0, 32'd0);
        send_pair(24'sd100, 24'sd5, 1'b0);
        send_pair(24'sd100, -24'sd7, 1'b0);
        send_pair(24'sd1, 24'sd1, 1'b0);
        send_pair(24'sd2, -24'sd2, 1'b0);
        send_pair(24'sd3, 24'sd9, 1'b1);
        send_pair(24'h800000, 24'h7FFFFF, 1'b0);
        send_pair(24'h7FFFFF, 24'h800000, 1'b0);
        send_pair(24'sd0, 24'sd0, 1'b0);
        send_pair(24'sd0, 24'sd0, 1'b0);
        wait_idle();
        // Write to an unused address is ignored, window keeps its setting
        apb_write(3'd4, 32'd9);
        send_pair(24'sd10, 24'sd20, 1'b0);
        send_pair(24'sd11, 24'sd19, 1'b0);
        wait_idle();

        // Random phases over extreme and random window settings
        stall_on = 1'b1;
        lens = '{1, 2, 3, 64, 65, 127, 5, 30};
        for (int p = 0; p < 14; p++) begin
            wl = (p < lens.size()) ? lens[p] : $urandom_range(2, 12);
            apb_write(3'd0, {$urandom_range(0, 1) ? 25'h1ABCDEF : 25'h0, wl[6:0]});
            for (int i = 0; i < 135; i++) random_pair($urandom_range(0, 9) < 5 ? 0 :
                                                      $urandom_range(1, 4));
            wait_idle();
            stall_on = (p % 3 != 2);
        end

        $display("sent %0d sample pairs over window lengths 0..127", pairs_sent);
        $display("checked %0d correlations, %0d degenerate", sb.checked, sb.degen_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #60ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== sim.f =====
src/rpc_pkg.sv
src/rolling_pearson_correlation_top.sv
tb/rolling_pearson_correlation_top_tb.sv
